// ===== rtl/piecewise_power_density_scale_unit_assert.svh =====
// ---------------------------------------------------------------------------
// piecewise power density scale: assertion macros
// shared property wrappers for the checker
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_POWER_DENSITY_SCALE_UNIT_ASSERT_SVH
`define PIECEWISE_POWER_DENSITY_SCALE_UNIT_ASSERT_SVH

// property checked outside reset
`define PWD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define PWD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pwd_pkg.sv =====
// ---------------------------------------------------------------------------
// pwd_pkg
// types, codes and constant tables of the piecewise power density scale unit
// ---------------------------------------------------------------------------
`default_nettype none

package pwd_pkg;

  // opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // 1.0 in Q4.12
  localparam logic [15:0] SCALE_ONE = 16'd4096;

  // one word from the front to the back
  typedef struct packed {
    logic        direct;   // result already known
    logic [15:0] result;
    logic [1:0]  status;
    logic [15:0] kr;
    logic [15:0] r0;
    logic [15:0] r1;
    logic [15:0] s0;
    logic [15:0] s1;
    logic [15:0] p;
  } job_t;

  // floor square root, used at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] nn;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    nn    = n;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > nn) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != '0) begin
        if (nn >= res + bit_v) begin
          nn  = nn - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // 2^(-2^-idx) in Q0.30, idx 1..16
  function automatic logic [29:0] root_const(input int idx);
    logic [63:0] r;
    r = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) begin
      if (i <= idx) r = isqrt64(r << 30);
    end
    return r[29:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pwd_front.sv =====
// ---------------------------------------------------------------------------
// pwd_front
// accepts words, keeps the breakpoint table and finds the segment
// ---------------------------------------------------------------------------
`default_nettype none

module pwd_front #(
  parameter int MAX_STEPS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire logic [1:0]       in_opcode,
  input  wire logic [15:0]      in_radius,
  input  wire logic [15:0]      in_scale_in,
  input  wire logic [15:0]      in_exponent,
  output logic                  q_push,
  output pwd_pkg::job_t         q_job,
  input  wire logic             q_full
);

  localparam int AW = $clog2(MAX_STEPS);
  localparam int CW = $clog2(MAX_STEPS + 1);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_RD   = 4'b0010,
    F_CMP  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [15:0]      last_r, last_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [15:0]      kr_r, kr_nxt;
  logic [47:0]      prev_r, prev_nxt;
  pwd_pkg::job_t    job_r, job_nxt;
  logic [47:0]      mem [MAX_STEPS];
  logic [47:0]      rdata_r;
  logic             wr_en;
  logic [15:0]      rd_rad, rd_scl;
  logic             accept;

  assign in_full = (state_r != F_IDLE);
  assign accept  = in_push && !in_full;
  assign q_push  = (state_r == F_PUSH) && !q_full;
  assign q_job   = job_r;
  assign rd_rad  = rdata_r[47:32];
  assign rd_scl  = rdata_r[31:16];

  // table storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[AW-1:0]] <= {in_radius, in_scale_in, in_exponent};
    end
    rdata_r <= mem[idx_r];
  end

  // control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    kr_nxt    = kr_r;
    prev_nxt  = prev_r;
    job_nxt   = job_r;
    wr_en     = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          job_nxt        = '0;
          job_nxt.direct = 1'b1;
          job_nxt.status = pwd_pkg::ST_OK;
          state_nxt      = F_PUSH;
          case (in_opcode)
            pwd_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            pwd_pkg::OP_APPEND: begin
              if (cnt_r == CW'(MAX_STEPS) || (cnt_r != '0 && in_radius <= last_r)) begin
                job_nxt.status = pwd_pkg::ST_IGNORED;
              end else begin
                wr_en    = 1'b1;
                last_nxt = in_radius;
                cnt_nxt  = cnt_r + CW'(1);
              end
            end
            pwd_pkg::OP_EVAL: begin
              if (cnt_r == '0) begin
                job_nxt.status = pwd_pkg::ST_EMPTY;
              end else begin
                kr_nxt    = in_radius;
                idx_nxt   = '0;
                state_nxt = F_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      F_RD: begin
        state_nxt = F_CMP;
      end
      F_CMP: begin
        if (kr_r < rd_rad) begin
          state_nxt = F_PUSH;
          if (idx_r == '0) begin
            job_nxt.result = rd_scl;
          end else if (prev_r[15:0] == '0) begin
            job_nxt.result = pwd_pkg::SCALE_ONE;
          end else begin
            job_nxt.direct = 1'b0;
            job_nxt.kr     = kr_r;
            job_nxt.r0     = prev_r[47:32];
            job_nxt.s0     = prev_r[31:16];
            job_nxt.p      = prev_r[15:0];
            job_nxt.r1     = rd_rad;
            job_nxt.s1     = rd_scl;
          end
        end else if (CW'(idx_r) + CW'(1) == cnt_r) begin
          job_nxt.result = rd_scl;
          state_nxt      = F_PUSH;
        end else begin
          prev_nxt  = rdata_r;
          idx_nxt   = idx_r + AW'(1);
          state_nxt = F_RD;
        end
      end
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    last_r <= last_nxt;
    idx_r  <= idx_nxt;
    kr_r   <= kr_nxt;
    prev_r <= prev_nxt;
    job_r  <= job_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/pwd_fifo.sv =====
// ---------------------------------------------------------------------------
// pwd_fifo
// two-entry queue of words between the front and the back
// ---------------------------------------------------------------------------
`default_nettype none

module pwd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pwd_pkg::job_t wdata,
  output logic               full,
  input  wire logic          pop,
  output pwd_pkg::job_t      rdata,
  output logic               empty
);

  pwd_pkg::job_t  ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = ent_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pwd_back.sv =====
// ---------------------------------------------------------------------------
// pwd_back
// interpolates one segment (divide, log2, exp2, scale) or passes a direct word; output register
// ---------------------------------------------------------------------------
`default_nettype none

module pwd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pwd_pkg::job_t q_job,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [15:0]        out_scale_out,
  output logic [1:0]         out_status
);

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_DIV  = 9'b000000010,
    B_PREP = 9'b000000100,
    B_LOG  = 9'b000001000,
    B_MULQ = 9'b000010000,
    B_EXP  = 9'b000100000,
    B_PWR  = 9'b001000000,
    B_MAG  = 9'b010000000,
    B_FIN  = 9'b100000000
  } bstate_t;

  bstate_t        state_r;
  pwd_pkg::job_t  job_r;
  logic [15:0]    rem_r, quo_r, y_r, frac_r, fp_r, mag_r;
  logic [3:0]     cnt_r, k_r;
  logic [4:0]     ip_r;
  logic [30:0]    r_r;
  logic [16:0]    pw_r;
  logic           oval_r;
  logic [15:0]    oscl_r;
  logic [1:0]     osts_r;

  logic [29:0]    root_tab [16];
  logic [15:0]    den;
  logic [16:0]    sh;
  logic           pos;
  logic [16:0]    x;
  logic [15:0]    q;
  logic [3:0]     k;
  logic [31:0]    ysq;
  logic [16:0]    sq;
  logic [20:0]    nl;
  logic [36:0]    eprod;
  logic [8:0]     ip9;
  logic [60:0]    rprod;
  logic signed [16:0] ds;
  logic [15:0]    absd;
  logic [32:0]    mprod;
  logic signed [17:0] res;
  logic [15:0]    res_sat;
  logic           out_free;

  // constant root table
  for (genvar g = 0; g < 16; g++) begin : g_root
    assign root_tab[g] = pwd_pkg::root_const(g + 1);
  end

  assign out_free = !oval_r || out_pop;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;

  // datapath
  always_comb begin
    den   = job_r.r1 - job_r.r0;
    sh    = {rem_r, 1'b0};
    pos   = !job_r.p[15];
    x     = pos ? {1'b0, quo_r} : (17'h10000 - {1'b0, quo_r});
    q     = pos ? job_r.p : (~job_r.p + 16'd1);
    k     = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) k = 4'(i);
    end
    ysq   = y_r * y_r;
    sq    = ysq[31:15];
    nl    = {5'(5'd16 - {1'b0, k_r}), 16'h0} - {5'd0, frac_r};
    eprod = nl * q;
    ip9   = eprod[36:28];
    rprod = r_r * root_tab[cnt_r];
    ds    = $signed({1'b0, job_r.s1}) - $signed({1'b0, job_r.s0});
    absd  = ds[16] ? 16'(-ds) : ds[15:0];
    mprod = absd * pw_r;
    if (ds[16]) begin
      res = pos ? ($signed({2'b0, job_r.s0}) - $signed({2'b0, mag_r}))
                : ($signed({2'b0, job_r.s1}) + $signed({2'b0, mag_r}));
    end else begin
      res = pos ? ($signed({2'b0, job_r.s0}) + $signed({2'b0, mag_r}))
                : ($signed({2'b0, job_r.s1}) - $signed({2'b0, mag_r}));
    end
    if (res[17])          res_sat = 16'h0000;
    else if (res[16])     res_sat = 16'hFFFF;
    else                  res_sat = res[15:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      oval_r  <= 1'b0;
    end else begin
      // output word valid flag
      if (state_r == B_FIN && out_free) begin
        oval_r <= 1'b1;
      end else if (oval_r && out_pop) begin
        oval_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            job_r <= q_job;
            rem_r <= q_job.kr - q_job.r0;
            cnt_r <= '0;
            state_r <= q_job.direct ? B_FIN : B_DIV;
          end
        end
        // restoring divide, one quotient bit a cycle
        B_DIV: begin
          if (sh >= {1'b0, den}) begin
            rem_r <= 16'(sh - {1'b0, den});
            quo_r <= {quo_r[14:0], 1'b1};
          end else begin
            rem_r <= sh[15:0];
            quo_r <= {quo_r[14:0], 1'b0};
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= B_PREP;
        end
        // normalize the base
        B_PREP: begin
          if (x == '0) begin
            pw_r    <= '0;
            state_r <= B_MAG;
          end else if (x[16]) begin
            pw_r    <= 17'h10000;
            state_r <= B_MAG;
          end else begin
            k_r     <= k;
            y_r     <= x[15:0] << (4'd15 - k);
            frac_r  <= '0;
            cnt_r   <= '0;
            state_r <= B_LOG;
          end
        end
        // log2 fraction by squaring, one bit a cycle
        B_LOG: begin
          frac_r <= {frac_r[14:0], sq[16]};
          y_r    <= sq[16] ? sq[16:1] : sq[15:0];
          cnt_r  <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= B_MULQ;
        end
        // scale the log by the exponent
        B_MULQ: begin
          if (ip9 > 9'd16) begin
            pw_r    <= '0;
            state_r <= B_MAG;
          end else begin
            ip_r    <= ip9[4:0];
            fp_r    <= eprod[27:12];
            r_r     <= 31'h4000_0000;
            cnt_r   <= '0;
            state_r <= B_EXP;
          end
        end
        // exp2 of the fraction, one root a cycle
        B_EXP: begin
          if (fp_r[4'd15 - cnt_r]) r_r <= rprod[60:30];
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= B_PWR;
        end
        B_PWR: begin
          pw_r    <= 17'(r_r >> (6'd14 + {1'b0, ip_r}));
          state_r <= B_MAG;
        end
        B_MAG: begin
          mag_r   <= mprod[31:16];
          state_r <= B_FIN;
        end
        // output register
        B_FIN: begin
          if (out_free) begin
            oscl_r  <= job_r.direct ? job_r.result : res_sat;
            osts_r  <= job_r.status;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_empty     = !oval_r;
  assign out_scale_out = oscl_r;
  assign out_status    = osts_r;

endmodule

`default_nettype wire

// ===== rtl/piecewise_power_density_scale_unit.sv =====
// ---------------------------------------------------------------------------
// piecewise power density scale unit
// breakpoint table with power-law interpolation between breakpoints
// ---------------------------------------------------------------------------
//  channel  | handshake           | fields
//  in       | in_push / in_full   | opcode, radius, scale_in, exponent
//  out      | out_pop / out_empty | scale_out, status
//
//  clear and append pass the front through F_IDLE and F_PUSH; evaluate scans the
//  table one breakpoint at a time through F_RD and F_CMP (one registered table read port)
//  the back runs an interpolated segment through a divide, a log2 and an exp2 step
//  and passes other words straight from B_IDLE to B_FIN
//  a two-word queue parts front and back; rst_n is synchronous, active low
//  a full output register stalls the back, a full queue stalls the front
// ---------------------------------------------------------------------------
`default_nettype none

module piecewise_power_density_scale_unit #(
  parameter int MAX_STEPS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_radius,
  input  wire logic [15:0] in_scale_in,
  input  wire logic signed [15:0] in_exponent,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [15:0]      out_scale_out,
  output logic [1:0]       out_status
);

  pwd_pkg::job_t  push_job, pop_job;
  logic           q_push, q_full, q_pop, q_empty;

  // front: table and search
  pwd_front #(.MAX_STEPS(MAX_STEPS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_opcode   (in_opcode),
    .in_radius   (in_radius),
    .in_scale_in (in_scale_in),
    .in_exponent (in_exponent),
    .q_push      (q_push),
    .q_job       (push_job),
    .q_full      (q_full)
  );

  // queue between the parts
  pwd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_job),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (pop_job),
    .empty (q_empty)
  );

  // back: arithmetic and output register
  pwd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_job         (pop_job),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_scale_out (out_scale_out),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

// ===== rtl/pwd_checker.sv =====
// ---------------------------------------------------------------------------
// pwd_checker
// port-level checks of the piecewise power density scale unit
// ---------------------------------------------------------------------------
`default_nettype none

`include "piecewise_power_density_scale_unit_assert.svh"

module pwd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [15:0] out_scale_out,
  input wire logic [1:0]  out_status
);

  logic        waiting;
  logic        flagged;
  logic        status_known;
  logic [17:0] out_word;

  // port views used by the checks
  assign waiting      = !out_empty && !out_pop;
  assign flagged      = !out_empty && (out_status != pwd_pkg::ST_OK);
  assign status_known = (out_status == pwd_pkg::ST_OK) ||
                        (out_status == pwd_pkg::ST_IGNORED) ||
                        (out_status == pwd_pkg::ST_EMPTY);
  assign out_word     = {out_scale_out, out_status};

  // nothing waits right after reset
  `PWD_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> out_empty && !in_full, "not idle after reset")

  // a waiting word holds until taken
  `PWD_ASSERT(a_hold, clk, rst_n, waiting |=> !out_empty && $stable(out_word), "word changed")

  // status is one of the three codes
  `PWD_ASSERT(a_status, clk, rst_n, !out_empty |-> status_known, "bad status code")

  // flagged words carry a zero scale
  `PWD_ASSERT(a_flag_zero, clk, rst_n, flagged |-> out_scale_out == '0, "flagged word has scale")

  // an accepted word leaves the front busy in the cycle after
  `PWD_ASSERT(a_busy, clk, rst_n, in_push && !in_full |=> in_full, "front took two words")

endmodule

bind piecewise_power_density_scale_unit pwd_checker u_pwd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_push       (in_push),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_scale_out (out_scale_out),
  .out_status    (out_status)
);

`default_nettype wire
